@@ src/erm_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// erm_pkg
// Shared types, constants and rounding helpers of the Euler rotation matrix
// generator: angle and coefficient formats, series constants, latencies.
// ---------------------------------------------------------------------------
package erm_pkg;

  // number formats
  localparam int unsigned COEF_FRAC_BITS = 14;
  localparam int unsigned ANGLE_WIDTH    = 16;
  localparam int unsigned COEF_W         = COEF_FRAC_BITS + 2;
  localparam int unsigned SUM_W          = COEF_W + 1;
  localparam int unsigned PROD_W         = 2 * COEF_W;

  // angle units: 1/64 degree
  localparam int unsigned FULL_TURN    = 23040;
  localparam int unsigned THREE_QUARTER = 17280;
  localparam int unsigned HALF_TURN    = 11520;
  localparam int unsigned QUARTER_TURN = 5760;
  localparam int unsigned EIGHTH_TURN  = 2880;
  localparam int unsigned TURN_W       = 15;
  localparam int unsigned OCT_W        = 12;

  // Q2.62 series constants
  localparam logic [63:0] PI_Q62   = 64'hC90FDAA22168C234;
  localparam logic [63:0] RAD_STEP = PI_Q62 / 64'd11520;
  localparam logic [63:0] ONE_Q62  = 64'd1 << 62;
  localparam int unsigned SERIES_TERMS = 12;

  // constant divider: one 16-bit digit per step, remainder below 1024
  localparam int unsigned DIGIT_W     = 16;
  localparam int unsigned DIGITS      = 64 / DIGIT_W;
  localparam int unsigned REM_W       = 10;
  localparam int unsigned VAL_W       = REM_W + DIGIT_W;
  localparam int unsigned RECIP_SHIFT = VAL_W;

  // pipeline depths
  localparam int unsigned TERM_LAT = 2 + 2 * DIGITS;
  localparam int unsigned TRIG_LAT = 6 + SERIES_TERMS * TERM_LAT + 2;
  localparam int unsigned MAT_LAT  = 5;
  localparam int unsigned PIPE_LAT = TRIG_LAT + MAT_LAT;

  localparam int unsigned LANE_SIN = 0;
  localparam int unsigned LANE_COS = 1;

  typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
  typedef logic signed [COEF_W-1:0]      coef_t;

  localparam coef_t COEF_ONE = coef_t'(2 ** COEF_FRAC_BITS);

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef struct packed {
    angle_t angle_x;
    angle_t angle_y;
    angle_t angle_z;
  } erm_in_t;

  typedef struct packed {
    coef_t m00;
    coef_t m01;
    coef_t m02;
    coef_t m10;
    coef_t m11;
    coef_t m12;
    coef_t m20;
    coef_t m21;
    coef_t m22;
  } erm_out_t;

  // sine and cosine of the three negated angles
  typedef struct packed {
    coef_t a;
    coef_t b;
    coef_t c;
    coef_t d;
    coef_t e;
    coef_t f;
  } erm_coef_t;

  typedef struct packed {
    logic [63:0] term;
    logic [63:0] sum;
  } erm_lane_t;

  typedef struct packed {
    erm_lane_t [1:0] lane;
    logic [63:0]     x2;
  } erm_series_t;

  // product to coefficient format, ties away from zero
  function automatic coef_t round_prod(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] rnd;
    mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    rnd = (mag + PROD_W'(2 ** (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
    return p[PROD_W-1] ? coef_t'(-rnd[COEF_W-1:0]) : coef_t'(rnd[COEF_W-1:0]);
  endfunction

  // clamp a sum to +-1.0
  function automatic coef_t sat_coef(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    hi = SUM_W'(2 ** COEF_FRAC_BITS);
    if (v > hi) begin
      return COEF_ONE;
    end else if (v < -hi) begin
      return -COEF_ONE;
    end
    return v[COEF_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ src/erm_term.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// erm_term
// One Taylor series term for the sine and cosine lanes: term * x^2 in Q2.62,
// exact division by the constant k(k+1), then add or subtract into the sum.
// ---------------------------------------------------------------------------
module erm_term #(
  parameter int unsigned DIV_SIN = 6,
  parameter int unsigned DIV_COS = 2,
  parameter bit          SUB     = 1'b1
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  erm_pkg::erm_series_t ser_i,
  output erm_pkg::erm_series_t ser_o
);
  import erm_pkg::*;

  logic [63:0] x2_q [1:TERM_LAT];

  // x^2 travels beside the lanes
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_q[1] <= ser_i.x2;
      for (int s = 2; s <= TERM_LAT; s++) begin
        x2_q[s] <= x2_q[s-1];
      end
    end
  end

  assign ser_o.x2 = x2_q[TERM_LAT];

  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    localparam int unsigned LaneDiv = (ln == LANE_SIN) ? DIV_SIN : DIV_COS;
    localparam logic [VAL_W-1:0] Recip = VAL_W'((64'd1 << RECIP_SHIFT) / LaneDiv);

    logic [63:0]  pp_ll_q, pp_hl_q, pp_lh_q, pp_hh_q;
    logic [63:0]  sum1_q;
    logic [127:0] full;

    // multiplier: four 32x32 partial products
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pp_ll_q <= {32'd0, ser_i.lane[ln].term[31:0]} * {32'd0, ser_i.x2[31:0]};
        pp_hl_q <= {32'd0, ser_i.lane[ln].term[63:32]} * {32'd0, ser_i.x2[31:0]};
        pp_lh_q <= {32'd0, ser_i.lane[ln].term[31:0]} * {32'd0, ser_i.x2[63:32]};
        pp_hh_q <= {32'd0, ser_i.lane[ln].term[63:32]} * {32'd0, ser_i.x2[63:32]};
        sum1_q  <= ser_i.lane[ln].sum;
      end
    end

    assign full = {pp_hh_q, 64'd0} + {32'd0, pp_hl_q, 32'd0}
                + {32'd0, pp_lh_q, 32'd0} + {64'd0, pp_ll_q};

    // digit pipeline state, index 0 is the product stage
    logic [63:0]       n_b_q    [0:DIGITS];
    logic [63:0]       quot_b_q [0:DIGITS];
    logic [REM_W-1:0]  rem_b_q  [0:DIGITS];
    logic [63:0]       sum_b_q  [0:DIGITS];

    // product shifted back to Q2.62
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_b_q[0]    <= full[125:62];
        quot_b_q[0] <= '0;
        rem_b_q[0]  <= '0;
        sum_b_q[0]  <= sum1_q;
      end
    end

    for (genvar dg = 0; dg < DIGITS; dg++) begin : g_digit
      logic [VAL_W-1:0]   val;
      logic [2*VAL_W-1:0] qmul;
      logic [VAL_W-1:0]   val_a_q;
      logic [DIGIT_W-1:0] qe_a_q;
      logic [63:0]        n_a_q, quot_a_q, sum_a_q;
      logic [VAL_W-1:0]   qd, rfull;
      logic               fix;
      logic [DIGIT_W-1:0] qdig;
      logic [63:0]        quot_new;

      // quotient estimate from the reciprocal
      assign val  = {rem_b_q[dg], n_b_q[dg][63:64-DIGIT_W]};
      assign qmul = {{VAL_W{1'b0}}, val} * {{VAL_W{1'b0}}, Recip};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          val_a_q  <= val;
          qe_a_q   <= qmul[RECIP_SHIFT +: DIGIT_W];
          n_a_q    <= n_b_q[dg] << DIGIT_W;
          quot_a_q <= quot_b_q[dg];
          sum_a_q  <= sum_b_q[dg];
        end
      end

      // remainder and one correction step
      assign qd       = VAL_W'({{(VAL_W-DIGIT_W){1'b0}}, qe_a_q} * VAL_W'(LaneDiv));
      assign rfull    = val_a_q - qd;
      assign fix      = (rfull >= VAL_W'(LaneDiv));
      assign qdig     = qe_a_q + DIGIT_W'(fix);
      assign quot_new = {quot_a_q[63-DIGIT_W:0], qdig};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          n_b_q[dg+1]    <= n_a_q;
          quot_b_q[dg+1] <= quot_new;
          rem_b_q[dg+1]  <= fix ? REM_W'(rfull - VAL_W'(LaneDiv)) : REM_W'(rfull);
          if (dg == DIGITS - 1) begin
            sum_b_q[dg+1] <= SUB ? (sum_a_q - quot_new) : (sum_a_q + quot_new);
          end else begin
            sum_b_q[dg+1] <= sum_a_q;
          end
        end
      end
    end

    assign ser_o.lane[ln].term = quot_b_q[DIGITS];
    assign ser_o.lane[ln].sum  = sum_b_q[DIGITS];
  end

endmodule
`default_nettype wire

@@ src/erm_trig.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// erm_trig
// Sine and cosine of minus one angle: reduction to one turn, octant fold,
// radians in Q2.62, twelve-term series, rounding and quadrant symmetry.
// ---------------------------------------------------------------------------
module erm_trig (
  input  logic            clk_i,
  input  logic            en_i,
  input  erm_pkg::angle_t angle_i,
  output erm_pkg::coef_t  sin_o,
  output erm_pkg::coef_t  cos_o
);
  import erm_pkg::*;

  localparam int unsigned META_LEN = 4 + SERIES_TERMS * TERM_LAT + 1;
  localparam int unsigned NEG_W    = ANGLE_WIDTH + 2;
  localparam int unsigned RAW_W    = COEF_FRAC_BITS + 1;

  localparam logic signed [NEG_W-1:0] TurnS  = NEG_W'(FULL_TURN);
  localparam logic signed [NEG_W-1:0] Turn2S = NEG_W'(2 * FULL_TURN);
  localparam logic [TURN_W-1:0] Q1 = TURN_W'(QUARTER_TURN);
  localparam logic [TURN_W-1:0] Q2 = TURN_W'(HALF_TURN);
  localparam logic [TURN_W-1:0] Q3 = TURN_W'(THREE_QUARTER);
  localparam logic [TURN_W-1:0] Q8 = TURN_W'(EIGHTH_TURN);

  typedef struct packed {
    quad_e quad;
    logic  swap;
  } meta_t;

  logic signed [NEG_W-1:0] neg_ang, red;
  logic [TURN_W-1:0]       m_q;

  // negate and reduce modulo one turn
  assign neg_ang = -NEG_W'(angle_i);

  always_comb begin
    if (neg_ang < -TurnS) begin
      red = neg_ang + Turn2S;
    end else if (neg_ang < 0) begin
      red = neg_ang + TurnS;
    end else if (neg_ang >= TurnS) begin
      red = neg_ang - TurnS;
    end else begin
      red = neg_ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q <= red[TURN_W-1:0];
    end
  end

  // quadrant split and octant fold
  logic [TURN_W-1:0] r;
  logic [OCT_W-1:0]  t_d, t_q;
  meta_t             meta_d;
  meta_t             meta_q [0:META_LEN];

  always_comb begin
    if (m_q >= Q3) begin
      meta_d.quad = QUAD_3;
      r           = m_q - Q3;
    end else if (m_q >= Q2) begin
      meta_d.quad = QUAD_2;
      r           = m_q - Q2;
    end else if (m_q >= Q1) begin
      meta_d.quad = QUAD_1;
      r           = m_q - Q1;
    end else begin
      meta_d.quad = QUAD_0;
      r           = m_q;
    end
    if (r <= Q8) begin
      meta_d.swap = 1'b0;
      t_d         = r[OCT_W-1:0];
    end else begin
      meta_d.swap = 1'b1;
      t_d         = OCT_W'(Q1 - r);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q        <= t_d;
      meta_q[0]  <= meta_d;
      for (int s = 1; s <= META_LEN; s++) begin
        meta_q[s] <= meta_q[s-1];
      end
    end
  end

  // angle to radians: two partial products
  logic [OCT_W+31:0] xlo_q, xhi_q;
  logic [63:0]       x_q, x5_q, x6_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xlo_q <= (OCT_W+32)'(t_q) * (OCT_W+32)'(RAD_STEP[31:0]);
      xhi_q <= (OCT_W+32)'(t_q) * (OCT_W+32)'(RAD_STEP[63:32]);
      x_q   <= 64'(xlo_q) + {xhi_q[31:0], 32'd0};
    end
  end

  // x squared in Q2.62
  logic [63:0]  sq_ll_q, sq_lh_q, sq_hh_q;
  logic [127:0] sq_full;
  logic [63:0]  x2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_ll_q <= {32'd0, x_q[31:0]} * {32'd0, x_q[31:0]};
      sq_lh_q <= {32'd0, x_q[31:0]} * {32'd0, x_q[63:32]};
      sq_hh_q <= {32'd0, x_q[63:32]} * {32'd0, x_q[63:32]};
      x5_q    <= x_q;
    end
  end

  assign sq_full = {sq_hh_q, 64'd0} + {31'd0, sq_lh_q, 33'd0} + {64'd0, sq_ll_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_q <= sq_full[125:62];
      x6_q <= x5_q;
    end
  end

  // series chain: sine lane starts at x, cosine lane at 1.0
  erm_series_t ser [0:SERIES_TERMS];

  assign ser[0].lane[LANE_SIN].term = x6_q;
  assign ser[0].lane[LANE_SIN].sum  = x6_q;
  assign ser[0].lane[LANE_COS].term = ONE_Q62;
  assign ser[0].lane[LANE_COS].sum  = ONE_Q62;
  assign ser[0].x2                  = x2_q;

  for (genvar i = 1; i <= SERIES_TERMS; i++) begin : g_term
    erm_term #(
      .DIV_SIN ((2 * i) * (2 * i + 1)),
      .DIV_COS ((2 * i - 1) * (2 * i)),
      .SUB     (i % 2 == 1)
    ) u_term (
      .clk_i (clk_i),
      .en_i  (en_i),
      .ser_i (ser[i-1]),
      .ser_o (ser[i])
    );
  end

  // round both sums to coefficient format
  logic [63:0]      s_rnd, c_rnd;
  logic [RAW_W-1:0] s_raw_q, c_raw_q;

  assign s_rnd = ser[SERIES_TERMS].lane[LANE_SIN].sum + (64'd1 << (61 - COEF_FRAC_BITS));
  assign c_rnd = ser[SERIES_TERMS].lane[LANE_COS].sum + (64'd1 << (61 - COEF_FRAC_BITS));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_raw_q <= s_rnd[62:62-COEF_FRAC_BITS];
      c_raw_q <= c_rnd[62:62-COEF_FRAC_BITS];
    end
  end

  // octant swap and quadrant signs
  coef_t s0, c0, sin_d, cos_d, sin_q, cos_q;
  meta_t mt;

  assign mt = meta_q[META_LEN];
  assign s0 = mt.swap ? coef_t'(c_raw_q) : coef_t'(s_raw_q);
  assign c0 = mt.swap ? coef_t'(s_raw_q) : coef_t'(c_raw_q);

  always_comb begin
    case (mt.quad)
      QUAD_0: begin
        sin_d = s0;
        cos_d = c0;
      end
      QUAD_1: begin
        sin_d = c0;
        cos_d = -s0;
      end
      QUAD_2: begin
        sin_d = -s0;
        cos_d = -c0;
      end
      QUAD_3: begin
        sin_d = -c0;
        cos_d = s0;
      end
      default: begin
        sin_d = s0;
        cos_d = c0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule
`default_nettype wire

@@ src/erm_matrix.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// erm_matrix
// Builds the nine matrix entries from the six sines and cosines: two levels
// of rounded products, then sums with saturation to +-1.0.
// ---------------------------------------------------------------------------
module erm_matrix (
  input  logic               clk_i,
  input  logic               en_i,
  input  erm_pkg::erm_coef_t coef_i,
  output erm_pkg::erm_out_t  mat_o
);
  import erm_pkg::*;

  typedef logic signed [PROD_W-1:0] prod_t;

  // first level products
  prod_t p_ce_q, p_cf_q, p_bc_q, p_ac_q, p_af_q, p_ae_q, p_bf_q, p_be_q, p_ad_q, p_bd_q;
  coef_t d1_q, e1_q, f1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_ce_q <= coef_i.c * coef_i.e;
      p_cf_q <= coef_i.c * coef_i.f;
      p_bc_q <= coef_i.b * coef_i.c;
      p_ac_q <= coef_i.a * coef_i.c;
      p_af_q <= coef_i.a * coef_i.f;
      p_ae_q <= coef_i.a * coef_i.e;
      p_bf_q <= coef_i.b * coef_i.f;
      p_be_q <= coef_i.b * coef_i.e;
      p_ad_q <= coef_i.a * coef_i.d;
      p_bd_q <= coef_i.b * coef_i.d;
      d1_q   <= coef_i.d;
      e1_q   <= coef_i.e;
      f1_q   <= coef_i.f;
    end
  end

  // round first level
  coef_t ce2_q, cf2_q, bc2_q, ac2_q, af2_q, ae2_q, bf2_q, be2_q, ad2_q, bd2_q;
  coef_t d2_q, e2_q, f2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ce2_q <= round_prod(p_ce_q);
      cf2_q <= round_prod(p_cf_q);
      bc2_q <= round_prod(p_bc_q);
      ac2_q <= round_prod(p_ac_q);
      af2_q <= round_prod(p_af_q);
      ae2_q <= round_prod(p_ae_q);
      bf2_q <= round_prod(p_bf_q);
      be2_q <= round_prod(p_be_q);
      ad2_q <= round_prod(p_ad_q);
      bd2_q <= round_prod(p_bd_q);
      d2_q  <= d1_q;
      e2_q  <= e1_q;
      f2_q  <= f1_q;
    end
  end

  // second level products
  prod_t p_bde_q, p_bdf_q, p_ade_q, p_adf_q;
  coef_t ce3_q, cf3_q, bc3_q, ac3_q, af3_q, ae3_q, bf3_q, be3_q, d3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_bde_q <= bd2_q * e2_q;
      p_bdf_q <= bd2_q * f2_q;
      p_ade_q <= ad2_q * e2_q;
      p_adf_q <= ad2_q * f2_q;
      ce3_q   <= ce2_q;
      cf3_q   <= cf2_q;
      bc3_q   <= bc2_q;
      ac3_q   <= ac2_q;
      af3_q   <= af2_q;
      ae3_q   <= ae2_q;
      bf3_q   <= bf2_q;
      be3_q   <= be2_q;
      d3_q    <= d2_q;
    end
  end

  // round second level
  coef_t bde4_q, bdf4_q, ade4_q, adf4_q;
  coef_t ce4_q, cf4_q, bc4_q, ac4_q, af4_q, ae4_q, bf4_q, be4_q, d4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bde4_q <= round_prod(p_bde_q);
      bdf4_q <= round_prod(p_bdf_q);
      ade4_q <= round_prod(p_ade_q);
      adf4_q <= round_prod(p_adf_q);
      ce4_q  <= ce3_q;
      cf4_q  <= cf3_q;
      bc4_q  <= bc3_q;
      ac4_q  <= ac3_q;
      af4_q  <= af3_q;
      ae4_q  <= ae3_q;
      bf4_q  <= bf3_q;
      be4_q  <= be3_q;
      d4_q   <= d3_q;
    end
  end

  // sums and saturation
  typedef logic signed [SUM_W-1:0] sum_t;
  erm_out_t mat_d, mat_q;

  always_comb begin
    mat_d.m00 = sat_coef(SUM_W'(ce4_q));
    mat_d.m01 = sat_coef(-SUM_W'(cf4_q));
    mat_d.m02 = sat_coef(SUM_W'(d4_q));
    mat_d.m10 = sat_coef(sum_t'(SUM_W'(bde4_q) + SUM_W'(af4_q)));
    mat_d.m11 = sat_coef(sum_t'(SUM_W'(ae4_q) - SUM_W'(bdf4_q)));
    mat_d.m12 = sat_coef(-SUM_W'(bc4_q));
    mat_d.m20 = sat_coef(sum_t'(SUM_W'(bf4_q) - SUM_W'(ade4_q)));
    mat_d.m21 = sat_coef(sum_t'(SUM_W'(adf4_q) + SUM_W'(be4_q)));
    mat_d.m22 = sat_coef(SUM_W'(ac4_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mat_q <= mat_d;
    end
  end

  assign mat_o = mat_q;

endmodule
`default_nettype wire

@@ src/euler_rotation_matrix_top.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// euler_rotation_matrix_top
// Euler angle rotation matrix generator, three angles in, nine Q1.14 out.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries angle_x, angle_y
//   and angle_z in 1/64 degree units. A transaction completes at a rising edge
//   with valid high and stall low. The output channel out_valid_o /
//   out_stall_i / out_data_o carries the nine entries, row-major, in Q1.14.
//   Throughput: one transaction per cycle while in_stall_o is low, set by the
//   fully pipelined series evaluator (each of the twelve series terms is a
//   64-bit multiply followed by a four-digit constant divider, ten register
//   stages per term). Each result passes the sine/cosine pipeline, the matrix
//   product stages and one output register before out_valid_o rises.
//   When the receiver stalls, the result waits in the output register and one
//   more arriving result goes into a skid register; only then does in_stall_o
//   rise and the pipeline hold, so nothing is dropped or repeated.
//   Reset clears all valid bits; the block accepts input in the first cycle
//   after reset is released.
// ---------------------------------------------------------------------------
module euler_rotation_matrix_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  erm_pkg::erm_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output erm_pkg::erm_out_t out_data_o
);
  import erm_pkg::*;

  logic      en;
  logic      skid_valid_q, out_valid_q;
  erm_out_t  skid_q, out_q;
  logic      vld_q [1:PIPE_LAT];
  erm_coef_t coef;
  erm_out_t  mat;
  logic      take, arrive;

  // pipeline advances unless the skid register is holding a result
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // valid bits beside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= PIPE_LAT; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else if (en) begin
      vld_q[1] <= in_valid_i;
      for (int s = 2; s <= PIPE_LAT; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  // sine and cosine of the three negated angles
  erm_trig u_trig_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_data_i.angle_x),
    .sin_o   (coef.b),
    .cos_o   (coef.a)
  );

  erm_trig u_trig_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_data_i.angle_y),
    .sin_o   (coef.d),
    .cos_o   (coef.c)
  );

  erm_trig u_trig_z (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_data_i.angle_z),
    .sin_o   (coef.f),
    .cos_o   (coef.e)
  );

  erm_matrix u_matrix (
    .clk_i  (clk_i),
    .en_i   (en),
    .coef_i (coef),
    .mat_o  (mat)
  );

  // output register with skid stage
  assign take   = out_valid_q && !out_stall_i;
  assign arrive = en && vld_q[PIPE_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (arrive) begin
      if (out_valid_q && !take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (arrive) begin
      if (out_valid_q && !take) begin
        skid_q <= mat;
      end else begin
        out_q <= mat;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
